FILE: rtl/assert_macros.svh
// Assertion helpers; every use needs clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at each rising edge, off while in reset.
`define SIT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Flag a condition that must never be seen.
`define SIT_ASSERT_NEVER(label, cond, msg) \
  `SIT_ASSERT(label, !(cond), msg)

`endif

FILE: rtl/sit_pkg.sv
`timescale 1ns / 1ps

package sit_pkg;

  localparam int COORD_BITS    = 16;
  localparam int DIFF_BITS     = COORD_BITS + 1;
  localparam int PROD_BITS     = 2 * DIFF_BITS;
  localparam int CROSS_BITS    = PROD_BITS + 1;
  localparam int IN_DATA_BITS  = ((8 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = 8;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [CROSS_BITS-1:0] cross_t;

  // last member sits in the lowest bits
  typedef struct packed {
    coord_t b_end_y;
    coord_t b_end_x;
    coord_t b_start_y;
    coord_t b_start_x;
    coord_t a_end_y;
    coord_t a_end_x;
    coord_t a_start_y;
    coord_t a_start_x;
  } seg_pair_t;

  // direction u of one segment, other segment's endpoints p and q relative to its start
  typedef struct packed {
    diff_t ux;
    diff_t uy;
    diff_t px;
    diff_t py;
    diff_t qx;
    diff_t qy;
  } rel_t;

  typedef struct packed {
    prod_t pa;
    prod_t pb;
    prod_t qa;
    prod_t qb;
  } prods_t;

  // bit k belongs to orientation d(k+1)
  typedef struct packed {
    logic       overlap;
    logic [3:0] on_box;
  } flags_t;

  typedef struct packed {
    logic [3:0] neg;
    logic [3:0] zero;
  } signs_t;

endpackage

FILE: rtl/sit_prep.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sit_prep (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sit_pkg::seg_pair_t pair,
  input  logic               dn_ready,
  output logic               out_valid,
  output sit_pkg::rel_t [1:0] rel,
  output sit_pkg::flags_t    flags
);
  import sit_pkg::*;

  logic        en;
  logic        vld_r, vld_nxt;
  rel_t [1:0]  rel_r, rel_nxt;
  flags_t      flg_r, flg_nxt;
  coord_t      a_min_x, a_max_x, a_min_y, a_max_y;
  coord_t      b_min_x, b_max_x, b_min_y, b_max_y;

  assign en       = !vld_r || dn_ready;
  assign in_ready = en;

  always_comb begin
    a_min_x = (pair.a_start_x < pair.a_end_x) ? pair.a_start_x : pair.a_end_x;
    a_max_x = (pair.a_start_x > pair.a_end_x) ? pair.a_start_x : pair.a_end_x;
    a_min_y = (pair.a_start_y < pair.a_end_y) ? pair.a_start_y : pair.a_end_y;
    a_max_y = (pair.a_start_y > pair.a_end_y) ? pair.a_start_y : pair.a_end_y;
    b_min_x = (pair.b_start_x < pair.b_end_x) ? pair.b_start_x : pair.b_end_x;
    b_max_x = (pair.b_start_x > pair.b_end_x) ? pair.b_start_x : pair.b_end_x;
    b_min_y = (pair.b_start_y < pair.b_end_y) ? pair.b_start_y : pair.b_end_y;
    b_max_y = (pair.b_start_y > pair.b_end_y) ? pair.b_start_y : pair.b_end_y;

    flg_nxt.overlap = (a_min_x <= b_max_x) && (b_min_x <= a_max_x) &&
                      (a_min_y <= b_max_y) && (b_min_y <= a_max_y);
    flg_nxt.on_box[0] = (pair.b_start_x >= a_min_x) && (pair.b_start_x <= a_max_x) &&
                        (pair.b_start_y >= a_min_y) && (pair.b_start_y <= a_max_y);
    flg_nxt.on_box[1] = (pair.b_end_x >= a_min_x) && (pair.b_end_x <= a_max_x) &&
                        (pair.b_end_y >= a_min_y) && (pair.b_end_y <= a_max_y);
    flg_nxt.on_box[2] = (pair.a_start_x >= b_min_x) && (pair.a_start_x <= b_max_x) &&
                        (pair.a_start_y >= b_min_y) && (pair.a_start_y <= b_max_y);
    flg_nxt.on_box[3] = (pair.a_end_x >= b_min_x) && (pair.a_end_x <= b_max_x) &&
                        (pair.a_end_y >= b_min_y) && (pair.a_end_y <= b_max_y);

    rel_nxt[0].ux = diff_t'(pair.a_end_x)   - diff_t'(pair.a_start_x);
    rel_nxt[0].uy = diff_t'(pair.a_end_y)   - diff_t'(pair.a_start_y);
    rel_nxt[0].px = diff_t'(pair.b_start_x) - diff_t'(pair.a_start_x);
    rel_nxt[0].py = diff_t'(pair.b_start_y) - diff_t'(pair.a_start_y);
    rel_nxt[0].qx = diff_t'(pair.b_end_x)   - diff_t'(pair.a_start_x);
    rel_nxt[0].qy = diff_t'(pair.b_end_y)   - diff_t'(pair.a_start_y);
    rel_nxt[1].ux = diff_t'(pair.b_end_x)   - diff_t'(pair.b_start_x);
    rel_nxt[1].uy = diff_t'(pair.b_end_y)   - diff_t'(pair.b_start_y);
    rel_nxt[1].px = diff_t'(pair.a_start_x) - diff_t'(pair.b_start_x);
    rel_nxt[1].py = diff_t'(pair.a_start_y) - diff_t'(pair.b_start_y);
    rel_nxt[1].qx = diff_t'(pair.a_end_x)   - diff_t'(pair.b_start_x);
    rel_nxt[1].qy = diff_t'(pair.a_end_y)   - diff_t'(pair.b_start_y);

    vld_nxt = en ? in_valid : vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      rel_r <= rel_nxt;
      flg_r <= flg_nxt;
    end
  end

  assign out_valid = vld_r;
  assign rel       = rel_r;
  assign flags     = flg_r;

  // a point in one box and on its own segment forces the boxes to overlap
  `SIT_ASSERT_NEVER(a_box_implies_overlap, vld_r && (flg_r.on_box != 4'b0) && !flg_r.overlap,
    "endpoint containment without box overlap")

endmodule

FILE: rtl/sit_mult.sv
`timescale 1ns / 1ps

module sit_mult (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sit_pkg::rel_t [1:0]  rel,
  input  sit_pkg::flags_t      in_flags,
  input  logic                 dn_ready,
  output logic                 out_valid,
  output sit_pkg::prods_t [1:0] prods,
  output sit_pkg::flags_t      out_flags
);
  import sit_pkg::*;

  logic          en;
  logic          vld_r, vld_nxt;
  prods_t [1:0]  prd_r, prd_nxt;
  flags_t        flg_r;

  assign en       = !vld_r || dn_ready;
  assign in_ready = en;

  always_comb begin
    for (int s = 0; s < 2; s++) begin
      prd_nxt[s].pa = prod_t'(rel[s].ux) * prod_t'(rel[s].py);
      prd_nxt[s].pb = prod_t'(rel[s].uy) * prod_t'(rel[s].px);
      prd_nxt[s].qa = prod_t'(rel[s].ux) * prod_t'(rel[s].qy);
      prd_nxt[s].qb = prod_t'(rel[s].uy) * prod_t'(rel[s].qx);
    end
    vld_nxt = en ? in_valid : vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      prd_r <= prd_nxt;
      flg_r <= in_flags;
    end
  end

  assign out_valid = vld_r;
  assign prods     = prd_r;
  assign out_flags = flg_r;

endmodule

FILE: rtl/sit_orient.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sit_orient (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sit_pkg::prods_t [1:0] prods,
  input  sit_pkg::flags_t       in_flags,
  input  logic                  dn_ready,
  output logic                  out_valid,
  output sit_pkg::signs_t       signs,
  output sit_pkg::flags_t       out_flags
);
  import sit_pkg::*;

  logic          en;
  logic          vld_r, vld_nxt;
  signs_t        sgn_r, sgn_nxt;
  flags_t        flg_r;
  cross_t [3:0]  cross_v;

  assign en       = !vld_r || dn_ready;
  assign in_ready = en;

  always_comb begin
    for (int s = 0; s < 2; s++) begin
      cross_v[2*s]   = cross_t'(prods[s].pa) - cross_t'(prods[s].pb);
      cross_v[2*s+1] = cross_t'(prods[s].qa) - cross_t'(prods[s].qb);
    end
    for (int k = 0; k < 4; k++) begin
      sgn_nxt.neg[k]  = cross_v[k][CROSS_BITS-1];
      sgn_nxt.zero[k] = (cross_v[k] == '0);
    end
    vld_nxt = en ? in_valid : vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      sgn_r <= sgn_nxt;
      flg_r <= in_flags;
    end
  end

  assign out_valid = vld_r;
  assign signs     = sgn_r;
  assign out_flags = flg_r;

  `SIT_ASSERT_NEVER(a_sign_exclusive, vld_r && ((sgn_r.neg & sgn_r.zero) != 4'b0),
    "orientation both negative and zero")

endmodule

FILE: rtl/segment_intersection_test.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Segment pair intersection test. Each input word carries two closed 2D segments
// A and B as signed coordinates; each one yields exactly one output word whose
// bit 0 is 1 when the segments share a point (touching endpoints and collinear
// overlap count). Four register stages (box compare and differences, cross
// products, orientation signs, decision), the first loaded at the accepting edge,
// lie between input and output, and one pair is taken every cycle as long as
// out_tready stays high. The block holds no state between words; a stall at the
// output backs up through the stage valid bits without losing or repeating
// data.
module segment_intersection_test (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
  input  logic [sit_pkg::IN_DATA_BITS-1:0] in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // intersects, then zero fill
  output logic [sit_pkg::OUT_DATA_BITS-1:0] out_tdata
);
  import sit_pkg::*;

  seg_pair_t     pair;
  logic          v1, v2, v3;
  logic          r2, r3, r4;
  rel_t [1:0]    rel;
  prods_t [1:0]  prods;
  flags_t        flg1, flg2, flg3;
  signs_t        signs;
  logic          en4;
  logic          vld_r, vld_nxt;
  logic          hit_r, hit_nxt;
  logic          opp_a, opp_b;

  assign pair = seg_pair_t'(in_tdata[8*COORD_BITS-1:0]);

  sit_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .pair      (pair),
    .dn_ready  (r2),
    .out_valid (v1),
    .rel       (rel),
    .flags     (flg1)
  );

  sit_mult u_mult (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v1),
    .in_ready  (r2),
    .rel       (rel),
    .in_flags  (flg1),
    .dn_ready  (r3),
    .out_valid (v2),
    .prods     (prods),
    .out_flags (flg2)
  );

  sit_orient u_orient (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v2),
    .in_ready  (r3),
    .prods     (prods),
    .in_flags  (flg2),
    .dn_ready  (r4),
    .out_valid (v3),
    .signs     (signs),
    .out_flags (flg3)
  );

  assign en4 = !vld_r || out_tready;
  assign r4  = en4;

  always_comb begin
    opp_a   = !signs.zero[0] && !signs.zero[1] && (signs.neg[0] != signs.neg[1]);
    opp_b   = !signs.zero[2] && !signs.zero[3] && (signs.neg[2] != signs.neg[3]);
    hit_nxt = flg3.overlap && ((opp_a && opp_b) || ((signs.zero & flg3.on_box) != 4'b0));
    vld_nxt = en4 ? v3 : vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en4 && v3) begin
      hit_r <= hit_nxt;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = OUT_DATA_BITS'(hit_r);

  `SIT_ASSERT(a_full_when_blocked, !in_tready |-> (v1 && v2 && v3 && vld_r && !out_tready),
    "input blocked while pipeline has room")
  `SIT_ASSERT(a_ready_passes, out_tready |-> in_tready,
    "input not ready although output is ready")

endmodule

FILE: verif/tb_segment_intersection_test.sv
`timescale 1ns / 1ps

module tb_segment_intersection_test;
  import sit_pkg::*;

  localparam int STALL_CYCLES = 300;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic [IN_DATA_BITS-1:0]  in_tdata = '0;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] out_tdata;

  bit pending_hits[$];
  int send_idle_pct = 10;
  int recv_idle_pct = 58;
  int stall_cnt = 0;
  int err_cnt = 0;
  int pairs_sent = 0;
  int hit_cnt = 0;
  int miss_cnt = 0;

  segment_intersection_test u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int orient_sign(input longint sx, input longint sy, input longint ex,
                                     input longint ey, input longint px, input longint py);
    longint c;
    c = (ex - sx) * (py - sy) - (ey - sy) * (px - sx);
    return (c > 0) ? 1 : ((c < 0) ? -1 : 0);
  endfunction

  function automatic bit in_box(input longint sx, input longint sy, input longint ex,
                                input longint ey, input longint px, input longint py);
    longint lox, hix, loy, hiy;
    lox = (sx < ex) ? sx : ex;
    hix = (sx < ex) ? ex : sx;
    loy = (sy < ey) ? sy : ey;
    hiy = (sy < ey) ? ey : sy;
    return (px >= lox) && (px <= hix) && (py >= loy) && (py <= hiy);
  endfunction

  function automatic bit segments_meet(input seg_pair_t p);
    longint asx, asy, aex, aey, bsx, bsy, bex, bey;
    int     d1, d2, d3, d4;
    bit     overlap;
    asx = $signed(p.a_start_x);
    asy = $signed(p.a_start_y);
    aex = $signed(p.a_end_x);
    aey = $signed(p.a_end_y);
    bsx = $signed(p.b_start_x);
    bsy = $signed(p.b_start_y);
    bex = $signed(p.b_end_x);
    bey = $signed(p.b_end_y);
    overlap = ((asx < aex ? asx : aex) <= (bsx > bex ? bsx : bex)) &&
              ((bsx < bex ? bsx : bex) <= (asx > aex ? asx : aex)) &&
              ((asy < aey ? asy : aey) <= (bsy > bey ? bsy : bey)) &&
              ((bsy < bey ? bsy : bey) <= (asy > aey ? asy : aey));
    if (!overlap) return 1'b0;
    d1 = orient_sign(asx, asy, aex, aey, bsx, bsy);
    d2 = orient_sign(asx, asy, aex, aey, bex, bey);
    d3 = orient_sign(bsx, bsy, bex, bey, asx, asy);
    d4 = orient_sign(bsx, bsy, bex, bey, aex, aey);
    if (d1 * d2 < 0 && d3 * d4 < 0) return 1'b1;
    if (d1 == 0 && in_box(asx, asy, aex, aey, bsx, bsy)) return 1'b1;
    if (d2 == 0 && in_box(asx, asy, aex, aey, bex, bey)) return 1'b1;
    if (d3 == 0 && in_box(bsx, bsy, bex, bey, asx, asy)) return 1'b1;
    if (d4 == 0 && in_box(bsx, bsy, bex, bey, aex, aey)) return 1'b1;
    return 1'b0;
  endfunction

  function automatic seg_pair_t mk_pair(input int asx, input int asy, input int aex,
                                        input int aey, input int bsx, input int bsy,
                                        input int bex, input int bey);
    seg_pair_t p;
    p.a_start_x = coord_t'(asx);
    p.a_start_y = coord_t'(asy);
    p.a_end_x   = coord_t'(aex);
    p.a_end_y   = coord_t'(aey);
    p.b_start_x = coord_t'(bsx);
    p.b_start_y = coord_t'(bsy);
    p.b_end_x   = coord_t'(bex);
    p.b_end_y   = coord_t'(bey);
    return p;
  endfunction

  function automatic seg_pair_t rand_pair();
    int c[8];
    int px, py, dx, dy, kind, i;
    kind = $urandom_range(99);
    px = int'($urandom_range(65535)) - 32768;
    py = int'($urandom_range(65535)) - 32768;
    dx = int'($urandom_range(10)) - 5;
    dy = int'($urandom_range(10)) - 5;
    if (kind < 40) begin
      return {$urandom, $urandom, $urandom, $urandom};
    end else if (kind < 65) begin
      // small cluster around a random origin
      for (i = 0; i < 8; i++) c[i] = ((i % 2) ? py : px) + int'($urandom_range(12)) - 6;
    end else if (kind < 77) begin
      // four points on a grid along one line, each either kept on that line or given its own y step
      for (i = 0; i < 4; i++) begin
        c[2*i]   = px + int'($urandom_range(6)) * dx;
        c[2*i+1] = py + int'($urandom_range(6)) * dy;
        if ($urandom_range(1)) c[2*i+1] = py + (c[2*i] - px) / ((dx == 0) ? 1 : dx) * dy;
      end
    end else if (kind < 89) begin
      // shared endpoint
      for (i = 0; i < 8; i++) c[i] = ((i % 2) ? py : px) + int'($urandom_range(20)) - 10;
      c[4] = c[2];
      c[5] = c[3];
      if ($urandom_range(1)) begin
        c[6] = c[0];
        c[7] = c[1];
      end
    end else begin
      // degenerate segment near or on the other
      i = $urandom_range(6);
      c[0] = px + i * dx;
      c[1] = py + i * dy + int'($urandom_range(2)) - 1;
      c[2] = c[0];
      c[3] = c[1];
      c[4] = px;
      c[5] = py;
      c[6] = px + 4 * dx;
      c[7] = py + 4 * dy;
      if ($urandom_range(3) == 0) begin
        c[4] = c[0];
        c[5] = c[1];
        c[6] = c[0];
        c[7] = c[1] + int'($urandom_range(1));
      end
      if ($urandom_range(1)) begin
        c = '{c[4], c[5], c[6], c[7], c[0], c[1], c[2], c[3]};
      end
    end
    return mk_pair(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
  endfunction

  task automatic flag_error(input string what);
    if (err_cnt < 10) $display("ERROR @%0t: %s", $realtime, what);
    err_cnt++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_cnt > 0) begin
      out_tready <= 1'b0;
      stall_cnt <= stall_cnt - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : scoreboard
    bit want;
    if (rst_n) begin
      if (in_tvalid && in_tready) pending_hits.push_back(segments_meet(in_tdata));
      if (out_tvalid && out_tready) begin
        if (pending_hits.size() == 0) begin
          flag_error($sformatf("unexpected word, intersects=%0b", out_tdata[0]));
        end else begin
          want = pending_hits.pop_front();
          if (out_tdata[0] !== want) begin
            flag_error($sformatf("intersects expected %0b actual %0b", want, out_tdata[0]));
          end
          if (want) hit_cnt++;
          else miss_cnt++;
        end
      end
    end
  end

  task automatic send_pair(input seg_pair_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= p;
    do @(posedge clk); while (!in_tready);
    pairs_sent++;
  endtask

  task automatic wait_drain();
    while (pending_hits.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic test_directed();
    seg_pair_t cases[$];
    cases.push_back(mk_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
    cases.push_back(mk_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    cases.push_back(mk_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    cases.push_back(mk_pair(-32768, -32768, 32767, 32766, -32768, -32767, 32767, 32767));
    cases.push_back(mk_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767));
    cases.push_back(mk_pair(32767, -32768, 32767, 32767, 32767, 0, 32767, 32767));
    cases.push_back(mk_pair(0, 0, 10, 10, 0, 10, 10, 0));
    cases.push_back(mk_pair(10, 10, 0, 0, 10, 0, 0, 10));
    cases.push_back(mk_pair(0, 0, 10, 0, 5, 0, 5, 7));
    cases.push_back(mk_pair(0, 0, 4, 4, 4, 4, 9, 1));
    cases.push_back(mk_pair(0, 0, 6, 0, 3, 0, 9, 0));
    cases.push_back(mk_pair(0, 0, 3, 0, 5, 0, 9, 0));
    cases.push_back(mk_pair(0, 0, 3, 3, 3, 3, 7, 7));
    cases.push_back(mk_pair(0, 0, 10, 10, 0, 10, 4, 6));
    cases.push_back(mk_pair(2, 2, 2, 2, 0, 0, 4, 4));
    cases.push_back(mk_pair(2, 3, 2, 3, 0, 0, 4, 4));
    cases.push_back(mk_pair(5, -5, 5, -5, 5, -5, 5, -5));
    cases.push_back(mk_pair(5, -5, 5, -5, 5, -4, 5, -4));
    cases.push_back(mk_pair(1, 1, 8, 3, 8, 3, 8, 3));
    cases.push_back(mk_pair(-100, -100, -50, -50, 50, 50, 100, 100));
    cases.push_back(mk_pair(0, 0, 32767, 1, 32767, 2, -32768, 0));
    cases.push_back(mk_pair(-32768, 32767, 32767, -32768, 0, 0, 0, 0));
    foreach (cases[i]) send_pair(cases[i]);
  endtask

  task automatic test_random(input int n_items, input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (n_items) send_pair(rand_pair());
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_cnt <= STALL_CYCLES;
    repeat (40) send_pair(rand_pair());
    in_tvalid <= 1'b0;
    wait_drain();
  endtask

  task automatic test_drain_pause();
    repeat (20) send_pair(rand_pair());
    in_tvalid <= 1'b0;
    wait_drain();
    repeat (20) send_pair(rand_pair());
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(290, 10, 58);
    test_backpressure();
    test_random(290, 58, 10);
    test_drain_pause();
    test_random(290, 0, 0);
    in_tvalid <= 1'b0;
    wait_drain();
    repeat (10) @(posedge clk);
    while (pending_hits.size() != 0) begin
      flag_error($sformatf("result never arrived, intersects=%0b", pending_hits.pop_front()));
    end
    $display("%0d segment pairs checked: %0d hits, %0d misses, extremes, degenerate,",
             pairs_sent, hit_cnt, miss_cnt);
    $display("collinear and touching cases; idle mixes 10/58, 58/10, none, %0d-cycle stall",
             STALL_CYCLES);
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d errors", err_cnt);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
